// ===== rtl/dpdt_pkg.sv =====
// Package for the debounced press duration timer.
// Register indexes, field widths, segment patterns and digit split helpers.
// No dependencies.
`default_nettype none

package dpdt_pkg;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE_THRESHOLD = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INTEGRATOR_MAX     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TICKS_PER_TENTH    = 2'd2;

  localparam logic [7:0]  RST_DEBOUNCE_THRESHOLD = 8'd3;
  localparam logic [7:0]  RST_INTEGRATOR_MAX     = 8'd5;
  localparam logic [15:0] RST_TICKS_PER_TENTH    = 16'd25;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [6:0] TENTHS_WRAP = 7'd100;
  localparam logic [6:0] TENTHS_MAX  = 7'd99;
  localparam logic [7:0] SEG_DP_MASK = 8'h01;  // decimal point, active low

  typedef logic [3:0] digit_t;
  typedef logic [7:0] seg_t;

  // active-low pattern, bits 7..1 = a..g, bit 0 = dp
  function automatic seg_t seg_encode(input digit_t d);
    seg_t s;
    case (d)
      4'd0:    s = 8'b00000011;
      4'd1:    s = 8'b10011111;
      4'd2:    s = 8'b00100101;
      4'd3:    s = 8'b00001101;
      4'd4:    s = 8'b10011001;
      4'd5:    s = 8'b01001001;
      4'd6:    s = 8'b01000001;
      4'd7:    s = 8'b00011111;
      4'd8:    s = 8'b00000001;
      4'd9:    s = 8'b00011001;
      default: s = 8'b11111111;
    endcase
    return s;
  endfunction

  // divide by ten through a reciprocal: exact for 0..99
  function automatic digit_t tens_of(input logic [6:0] v);
    logic [14:0] prod;
    prod = {8'd0, v} * 15'd205;
    return prod[14:11];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/debounced_press_duration_timer.sv =====
// Debounced press duration timer, top level.
// Integrating debouncer, tenths counter and seven-segment encode; uses dpdt_pkg.
//
// Usage:
//   Input stream (in_*): one request per tick, in_tdata[0] is the raw button
//   level. Each request updates the debounce integrator, the tick prescaler
//   and the tenths counter, then produces exactly one result request.
//   Result stream (out_*): pressed flag, elapsed tenths (0..99) and the
//   active-low segment bytes of the tens digit (decimal point lit) and of
//   the ones digit.
//   Config port: cfg_wen writes cfg_wdata to register cfg_addr
//   (0 threshold, 1 integrator ceiling, 2 ticks per tenth); index 3 is
//   ignored. Write only while no request is outstanding.
// Timing:
//   All work is one combinational pass from the state registers into the
//   result register: out_tvalid rises in the cycle after accept, and a
//   new request is accepted every cycle as long as the result register is
//   empty or being drained in the same cycle.
// Reset (rst_n low, synchronous): integrator, prescaler and tenths clear,
//   registers go to 3 / 5 / 25 and the result register empties.
// Stall: while out_tready is low a held result keeps out_tdata stable and
//   in_tready drops, so no tick is lost.
`default_nettype none

module debounced_press_duration_timer
  import dpdt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // config write port
  input  wire logic                  cfg_wen,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // input stream
  input  wire logic                  in_tvalid,
  output      logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [0] button_level, [7:1] zero
  // result stream
  output      logic                  out_tvalid,
  input  wire logic                  out_tready,
  output      logic [OUT_DATA_W-1:0] out_tdata   // [0] pressed, [7:1] elapsed_tenths,
                                                 // [15:8] tens_segments,
                                                 // [23:16] ones_segments
);

  // configuration
  logic [7:0]  threshold_r;
  logic [7:0]  integ_max_r;
  logic [15:0] ticks_per_tenth_r;

  // tick state
  logic [7:0]  integ_r,   integ_nxt;
  logic [15:0] presc_r,   presc_nxt;
  logic [6:0]  tenths_r,  tenths_nxt;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r,  out_data_nxt;

  logic        accept;
  logic        level;
  logic        pressed;
  logic [16:0] presc_inc;
  logic [6:0]  tenths_inc;
  digit_t      tens_d;
  digit_t      ones_d;
  logic [7:0]  tens_x10;
  seg_t        tens_seg;
  seg_t        ones_seg;

  // accept whenever the result slot is free or emptying this cycle
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign level     = in_tdata[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r       <= RST_DEBOUNCE_THRESHOLD;
      integ_max_r       <= RST_INTEGRATOR_MAX;
      ticks_per_tenth_r <= RST_TICKS_PER_TENTH;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_DEBOUNCE_THRESHOLD: threshold_r       <= cfg_wdata[7:0];
        REG_INTEGRATOR_MAX:     integ_max_r       <= cfg_wdata[7:0];
        REG_TICKS_PER_TENTH:    ticks_per_tenth_r <= cfg_wdata;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // per-tick update
  always_comb begin
    integ_nxt = integ_r;
    if (level && (integ_r < integ_max_r)) begin
      integ_nxt = integ_r + 8'd1;
    end else if (!level && (integ_r != 8'd0)) begin
      integ_nxt = integ_r - 8'd1;
    end

    pressed    = (integ_nxt >= threshold_r);
    presc_inc  = {1'b0, presc_r} + 17'd1;
    tenths_inc = tenths_r + 7'd1;

    presc_nxt  = 16'd0;
    tenths_nxt = 7'd0;
    if (pressed) begin
      // ticks_per_tenth of zero always passes, same as one
      if (presc_inc >= {1'b0, ticks_per_tenth_r}) begin
        presc_nxt  = 16'd0;
        tenths_nxt = (tenths_inc >= TENTHS_WRAP) ? 7'd0 : tenths_inc;
      end else begin
        presc_nxt  = presc_inc[15:0];
        tenths_nxt = tenths_r;
      end
    end
  end

  // digit split and segment encode
  always_comb begin
    tens_d   = tens_of(tenths_nxt);
    tens_x10 = {1'b0, tens_d, 3'd0} + {3'd0, tens_d, 1'b0};
    ones_d   = 4'(tenths_nxt - tens_x10[6:0]);
    tens_seg = seg_encode(tens_d) & ~SEG_DP_MASK;
    ones_seg = seg_encode(ones_d);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {ones_seg, tens_seg, tenths_nxt, pressed};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r     <= '0;
      presc_r     <= '0;
      tenths_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        integ_r  <= integ_nxt;
        presc_r  <= presc_nxt;
        tenths_r <= tenths_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/dpdt_checker.sv =====
// Port-level checker for the debounced press duration timer, with its bind.
// Watches the result stream over time; uses dpdt_pkg.
`default_nettype none

module dpdt_checker
  import dpdt_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  // a held result must not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // reset empties the result slot
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // one accepted tick gives a result on the next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted tick produced no result");

  // released means the count is cleared; count stays below the wrap
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:1] <= TENTHS_MAX) &&
                   (out_tdata[0] || (out_tdata[7:1] == 7'd0)))
    else $error("elapsed tenths out of range or not cleared");

  // tens digit always shows its decimal point
  a_tens_dp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[8])
    else $error("tens decimal point dark");

endmodule

bind debounced_press_duration_timer dpdt_checker u_dpdt_checker (.*);

`default_nettype wire
